// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PCS_ASSERT_IMP(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define PCS_ASSERT_NXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PCS_ASSERT_IMP(lbl, c, r, ante, cons)
`define PCS_ASSERT_NXT(lbl, c, r, ante, cons)
`endif
`endif

// File: src/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the PID step block
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int DATA_W        = 32;
  localparam int PERIOD_W      = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_AW        = 5;
  localparam int REG_IDX_W     = 3;

  // register indexes (byte address is 4 times the index)
  localparam logic [REG_IDX_W-1:0] REG_TARGET  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIM_LO  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LIM_HI  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_AUTO    = 3'd7;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] target_value;
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic signed [DATA_W-1:0] limit_low;
    logic signed [DATA_W-1:0] limit_high;
    logic [PERIOD_W-1:0]      period_ms;
    logic                     auto_mode;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DECIDE,
    OP_MUL_I,
    OP_ADD_I,
    OP_MUL_P,
    OP_ACC_P,
    OP_DERIV,
    OP_MUL_D,
    OP_ACC_D,
    OP_FINISH,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic auto_mode;
    logic due;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL_I,
    S_ADD_I,
    S_MUL_P,
    S_ACC_P,
    S_WAIT_DIV,
    S_MUL_D,
    S_ACC_D,
    S_FINISH,
    S_PUSH
  } state_t;

endpackage

// File: src/pcs_if.sv
// ----------------------------------------------------------------------------
// pcs_if
// Valid/ready channels for measurements and drive results
// ----------------------------------------------------------------------------
interface pcs_in_if import pcs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] measured;
  logic [DATA_W-1:0]        now_ms;

  modport source (output valid, output measured, output now_ms, input ready);
  modport sink   (input valid, input measured, input now_ms, output ready);
endinterface

interface pcs_out_if import pcs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic                     computed;

  modport source (output valid, output drive, output computed, input ready);
  modport sink   (input valid, input drive, input computed, output ready);
endinterface

// File: src/pcs_div.sv
// ----------------------------------------------------------------------------
// pcs_div
// Radix-2 restoring divider, unsigned, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pcs_div import pcs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              busy,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   shifted;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DATA_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top bit can be dropped
      if (!trial[DATA_W]) begin
        rem_r <= trial[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// File: src/pcs_dp.sv
// ----------------------------------------------------------------------------
// pcs_dp
// Datapath: shared multiplier, accumulator, clamps, divider and PID state
// ----------------------------------------------------------------------------
module pcs_dp import pcs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic signed [DATA_W-1:0] in_measured,
  input  logic [DATA_W-1:0]        in_now_ms,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_drive,
  output logic                     out_computed
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int SC_W   = PROD_W - FRAC_BITS;
  // two scaled products plus the integral
  localparam int ACC_W  = SC_W + 2;

  function automatic logic signed [DATA_W-1:0] clamp_acc(
    input logic signed [ACC_W-1:0]  v,
    input logic signed [DATA_W-1:0] lo,
    input logic signed [DATA_W-1:0] hi
  );
    logic signed [ACC_W-1:0] lo_x;
    logic signed [ACC_W-1:0] hi_x;
    logic signed [DATA_W-1:0] res;
    lo_x = ACC_W'(lo);
    hi_x = ACC_W'(hi);
    if (v > hi_x) begin
      res = hi;
    end else if (v < lo_x) begin
      res = lo;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

  // latched item and working registers
  logic signed [DATA_W-1:0] meas_r;
  logic [DATA_W-1:0]        now_r;
  logic signed [DATA_W-1:0] err_r;
  logic [DATA_W-1:0]        elapsed_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DATA_W-1:0] deriv_r;
  logic                     dneg_r;
  logic signed [DATA_W-1:0] res_drive_r;
  logic                     res_comp_r;

  // controller state that survives between items
  logic signed [DATA_W-1:0] integ_r;
  logic signed [DATA_W-1:0] prev_err_r;
  logic [DATA_W-1:0]        prev_time_r;
  logic signed [DATA_W-1:0] prev_drive_r;
  logic                     was_auto_r;
  logic                     started_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_drive_r;
  logic                     out_comp_r;

  logic [PERIOD_W-1:0]      period;
  logic [DATA_W-1:0]        period_x;
  logic [DATA_W-1:0]        elapsed;
  logic                     due;
  logic signed [DATA_W:0]   err_wide;
  logic signed [DATA_W-1:0] err_sat;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [SC_W-1:0]   prod_sc;
  logic signed [ACC_W-1:0]  sc_x;
  logic signed [ACC_W-1:0]  integ_x;
  logic signed [DATA_W:0]   ediff;
  logic [DATA_W:0]          emag;
  logic                     div_busy;
  logic [DATA_W-1:0]        quo;
  logic signed [DATA_W-1:0] deriv_sat;
  logic signed [DATA_W-1:0] seed;
  logic signed [DATA_W-1:0] integ_new;
  logic signed [DATA_W-1:0] drv;

  assign period   = (cfg.period_ms == '0) ? PERIOD_W'(1) : cfg.period_ms;
  assign period_x = DATA_W'(period);
  assign elapsed  = started_r ? (now_r - prev_time_r) : period_x;
  assign due      = (elapsed >= period_x);

  assign err_wide = (DATA_W+1)'(cfg.target_value) - (DATA_W+1)'(meas_r);
  always_comb begin
    if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
      err_sat = err_wide[DATA_W] ? S32_MIN : S32_MAX;
    end else begin
      err_sat = err_wide[DATA_W-1:0];
    end
  end

  always_comb begin
    case (cmd.op)
      OP_MUL_I: begin
        mul_a = cfg.gain_i;
        mul_b = err_r;
      end
      OP_MUL_P: begin
        mul_a = cfg.gain_p;
        mul_b = err_r;
      end
      default: begin
        mul_a = cfg.gain_d;
        mul_b = deriv_r;
      end
    endcase
  end

  // arithmetic shift of the product: rounds toward minus infinity
  assign prod_sc = prod_r[PROD_W-1:FRAC_BITS];
  assign sc_x    = ACC_W'(prod_sc);
  assign integ_x = ACC_W'(integ_r);

  assign ediff = (DATA_W+1)'(err_r) - (DATA_W+1)'(prev_err_r);
  assign emag  = ediff[DATA_W] ? (DATA_W+1)'(-ediff) : ediff;

  pcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (emag[DATA_W-1:0]),
    .divisor  (elapsed_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    if (!dneg_r) begin
      deriv_sat = quo[DATA_W-1] ? S32_MAX : quo;
    end else begin
      deriv_sat = (quo > DATA_W'(S32_MIN)) ? S32_MIN : -quo;
    end
  end

  assign seed      = clamp_acc(ACC_W'(prev_drive_r), cfg.limit_low, cfg.limit_high);
  assign integ_new = clamp_acc(integ_x + sc_x, cfg.limit_low, cfg.limit_high);
  assign drv       = clamp_acc(acc_r, cfg.limit_low, cfg.limit_high);

  // persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r      <= '0;
      prev_err_r   <= '0;
      prev_time_r  <= '0;
      prev_drive_r <= '0;
      was_auto_r   <= 1'b0;
      started_r    <= 1'b0;
    end else begin
      case (cmd.op)
        OP_DECIDE: begin
          if (!cfg.auto_mode) begin
            prev_drive_r <= cfg.target_value;
            was_auto_r   <= 1'b0;
          end else if (!was_auto_r) begin
            // entering automatic: seed from the last drive
            integ_r    <= seed;
            was_auto_r <= 1'b1;
          end
        end
        OP_ADD_I: begin
          integ_r <= integ_new;
        end
        OP_FINISH: begin
          prev_drive_r <= drv;
          prev_err_r   <= err_r;
          prev_time_r  <= now_r;
          started_r    <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        meas_r <= in_measured;
        now_r  <= in_now_ms;
      end
      OP_DECIDE: begin
        err_r     <= err_sat;
        elapsed_r <= elapsed;
        if (!cfg.auto_mode) begin
          res_drive_r <= cfg.target_value;
          res_comp_r  <= 1'b1;
        end else begin
          res_drive_r <= '0;
          res_comp_r  <= 1'b0;
        end
      end
      OP_MUL_I, OP_MUL_P, OP_MUL_D: begin
        prod_r <= mul_a * mul_b;
      end
      OP_ACC_P: begin
        acc_r <= sc_x + integ_x;
      end
      OP_DERIV: begin
        deriv_r <= deriv_sat;
      end
      OP_ACC_D: begin
        acc_r <= acc_r + sc_x;
      end
      OP_FINISH: begin
        res_drive_r <= drv;
        res_comp_r  <= 1'b1;
      end
      default: begin
      end
    endcase
    if (cmd.div_start) begin
      dneg_r <= ediff[DATA_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_PUSH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUSH) begin
      out_drive_r <= res_drive_r;
      out_comp_r  <= res_comp_r;
    end
  end

  assign stat.auto_mode = cfg.auto_mode;
  assign stat.due       = due;
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_drive    = out_drive_r;
  assign out_computed = out_comp_r;

endmodule

// File: src/pcs_ctrl.sv
// ----------------------------------------------------------------------------
// pcs_ctrl
// Step sequencer: walks the datapath through each item, with the PID update only for a due automatic item
// ----------------------------------------------------------------------------
module pcs_ctrl import pcs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.op    = OP_DECIDE;
        state_nxt = (stat.auto_mode && stat.due) ? S_MUL_I : S_PUSH;
      end
      S_MUL_I: begin
        // derivative division runs alongside the integral and p terms
        cmd.op        = OP_MUL_I;
        cmd.div_start = 1'b1;
        state_nxt     = S_ADD_I;
      end
      S_ADD_I: begin
        cmd.op    = OP_ADD_I;
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.op    = OP_MUL_P;
        state_nxt = S_ACC_P;
      end
      S_ACC_P: begin
        cmd.op    = OP_ACC_P;
        state_nxt = S_WAIT_DIV;
      end
      S_WAIT_DIV: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_DERIV;
          state_nxt = S_MUL_D;
        end
      end
      S_MUL_D: begin
        cmd.op    = OP_MUL_D;
        state_nxt = S_ACC_D;
      end
      S_ACC_D: begin
        cmd.op    = OP_ACC_D;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.op    = OP_FINISH;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/pid_controller_step_top.sv
// Manual and not-due items skip the PID arithmetic and go from the decide state
// to the push; computed automatic steps also wait for the radix-2 divider that
// forms the derivative, and a stall on the output holds the result. One item is
// in flight at a time: a new item is taken only after the last one is pushed.
// Reset (synchronous, active low) loads the register defaults and clears the
// integral, history and mode tracking; the block then starts idle and takes items.
// ----------------------------------------------------------------------------
// pid_controller_step_top
// PID step with clamped integral and output, APB register port
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_controller_step_top import pcs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pcs_in_if.sink            in_ch,
  pcs_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t                 cfg_r;
  dp_cmd_t              dp_cmd;
  dp_stat_t             dp_stat;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_value <= '0;
      cfg_r.gain_p       <= 32'sd65536;
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
      cfg_r.limit_low    <= S32_MIN;
      cfg_r.limit_high   <= S32_MAX;
      cfg_r.period_ms    <= PERIOD_W'(100);
      cfg_r.auto_mode    <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TARGET: cfg_r.target_value <= pwdata;
        REG_GAIN_P: cfg_r.gain_p       <= pwdata;
        REG_GAIN_I: cfg_r.gain_i       <= pwdata;
        REG_GAIN_D: cfg_r.gain_d       <= pwdata;
        REG_LIM_LO: cfg_r.limit_low    <= pwdata;
        REG_LIM_HI: cfg_r.limit_high   <= pwdata;
        REG_PERIOD: cfg_r.period_ms    <= pwdata[PERIOD_W-1:0];
        REG_AUTO:   cfg_r.auto_mode    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TARGET: prdata = cfg_r.target_value;
      REG_GAIN_P: prdata = cfg_r.gain_p;
      REG_GAIN_I: prdata = cfg_r.gain_i;
      REG_GAIN_D: prdata = cfg_r.gain_d;
      REG_LIM_LO: prdata = cfg_r.limit_low;
      REG_LIM_HI: prdata = cfg_r.limit_high;
      REG_PERIOD: prdata = DATA_W'(cfg_r.period_ms);
      REG_AUTO:   prdata = DATA_W'(cfg_r.auto_mode);
      default:    prdata = '0;
    endcase
  end

  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  pcs_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .in_measured  (in_ch.measured),
    .in_now_ms    (in_ch.now_ms),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_drive    (out_ch.drive),
    .out_computed (out_ch.computed)
  );

  // one item in flight: a transfer closes the input for the next cycle
  `PCS_ASSERT_NXT(a_one_item, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  // divider is never restarted while still iterating
  `PCS_ASSERT_IMP(a_div_start_idle, clk, rst_n, dp_cmd.div_start, !dp_stat.div_busy)
  // quotient is only taken once the divider has finished
  `PCS_ASSERT_IMP(a_deriv_done, clk, rst_n, dp_cmd.op == OP_DERIV, !dp_stat.div_busy)
  // a pushed result is presented on the next cycle
  `PCS_ASSERT_NXT(a_push_shows, clk, rst_n, dp_cmd.op == OP_PUSH, out_ch.valid)

endmodule
